// ===== design/bas_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bas_pkg: shared types and constants
// Scanner modes, closer codes, status codes and character helpers for the
// balanced argument splitter.
// ----------------------------------------------------------------------------
package bas_pkg;

   typedef enum logic [1:0] {
      MODE_SCAN   = 2'd0,
      MODE_STRING = 2'd1,
      MODE_ESCAPE = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      CL_NONE    = 2'd0,
      CL_PAREN   = 2'd1,
      CL_BRACE   = 2'd2,
      CL_BRACKET = 2'd3
   } closer_type;

   typedef enum logic [2:0] {
      ST_ACCEPT     = 3'd0,
      ST_SEP        = 3'd1,
      ST_TERM       = 3'd2,
      ST_EOS_SCAN   = 3'd3,
      ST_EOS_STRING = 3'd4,
      ST_EOS_ESCAPE = 3'd5,
      ST_OVERFLOW   = 3'd6
   } status_type;

   typedef enum logic [0:0] {
      CSR_SEPARATOR  = 1'b0,
      CSR_TERMINATOR = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic push;
      logic pop;
   } stack_cmd_type;

   localparam logic [7:0] CHAR_LPAREN    = 8'h28;
   localparam logic [7:0] CHAR_LBRACE    = 8'h7B;
   localparam logic [7:0] CHAR_LBRACKET  = 8'h5B;
   localparam logic [7:0] CHAR_RPAREN    = 8'h29;
   localparam logic [7:0] CHAR_RBRACE    = 8'h7D;
   localparam logic [7:0] CHAR_RBRACKET  = 8'h5D;
   localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
   localparam logic [7:0] CHAR_SQUOTE    = 8'h27;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_BACKTICK  = 8'h60;

   localparam logic [7:0] SEPARATOR_RESET  = 8'd44;
   localparam logic [7:0] TERMINATOR_RESET = 8'd41;

   function automatic closer_type opener_kind(input logic [7:0] c);
      closer_type k;
      k = CL_NONE;
      if (c == CHAR_LPAREN) k = CL_PAREN;
      else if (c == CHAR_LBRACE) k = CL_BRACE;
      else if (c == CHAR_LBRACKET) k = CL_BRACKET;
      return k;
   endfunction

   // the none code has no closing character and never matches
   function automatic logic closer_match(input closer_type k, input logic [7:0] c);
      logic m;
      m = 1'b0;
      unique case (k)
         CL_PAREN:   m = (c == CHAR_RPAREN);
         CL_BRACE:   m = (c == CHAR_RBRACE);
         CL_BRACKET: m = (c == CHAR_RBRACKET);
         default:    m = 1'b0;
      endcase
      return m;
   endfunction

endpackage

// ===== design/bas_stack_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bas_stack_cell: one entry of the closer stack
// Holds one saved closer code. On push it takes its upper neighbor's code,
// on pop its lower neighbor's code, so the row moves as a shift stack.
// ----------------------------------------------------------------------------
module bas_stack_cell (
   input  logic                   clock,
   input  bas_pkg::stack_cmd_type cmd,
   input  bas_pkg::closer_type    above,
   input  bas_pkg::closer_type    below,
   output bas_pkg::closer_type    value
);
   import bas_pkg::*;

   closer_type value_ff;
   closer_type value_in;

   always_comb begin
      value_in = value_ff;
      if (cmd.push) begin
         value_in = above;
      end else if (cmd.pop) begin
         value_in = below;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

// ===== design/balanced_argument_splitter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// balanced_argument_splitter: one-argument scanner with nesting tracking
// Echoes characters of a call argument and reports where it ends.
// ----------------------------------------------------------------------------
// Takes one character word per clock and returns exactly one result word per
// input word in the next cycle, at a sustained rate of one word per cycle while
// the result side does not stall. The scanner update (mode, nesting depth,
// expected closer and a one-step shift of the closer stack) is combinational
// and feeds the state registers. The closer stack is a row of MAX_NEST cells that shift down
// on an opener and up on a matching closer; the top closer lives in a
// register of its own. The result sits in an output register; input is
// stalled only while that register is full and the result side stalls.
// separator_char and terminator_char must be written through the csr port only
// while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module balanced_argument_splitter #(
   parameter int MAX_NEST = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_char,
   input  logic       req_at_end,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_echo_char,
   output logic [2:0] rsp_status,
   input  logic       csr_wr_en,
   input  logic [0:0] csr_index,
   input  logic [7:0] csr_wdata
);
   import bas_pkg::*;

   localparam int DEPTH_W = $clog2(MAX_NEST + 1);
   localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_NEST);

   logic [7:0]         separator_ff;
   logic [7:0]         terminator_ff;
   mode_type           mode_ff, mode_in;
   logic               quote_ff, quote_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   closer_type         expect_ff, expect_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         echo_ff, echo_in;
   status_type         status_ff, status_in;

   stack_cmd_type      stack_cmd;
   closer_type         stack_value [MAX_NEST];
   logic               req_fire;
   closer_type         op;
   logic [7:0]         delim;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_fire  = req_valid & ~req_stall;
   assign op        = opener_kind(req_in_char);
   assign delim     = quote_ff ? CHAR_SQUOTE : CHAR_DQUOTE;

   always_comb begin
      mode_in      = mode_ff;
      quote_in     = quote_ff;
      depth_in     = depth_ff;
      expect_in    = expect_ff;
      stack_cmd    = '0;
      echo_in      = echo_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
         echo_in      = 8'd0;
         status_in    = ST_ACCEPT;
         if (req_at_end) begin
            unique case (mode_ff)
               MODE_STRING: status_in = ST_EOS_STRING;
               MODE_ESCAPE: status_in = ST_EOS_ESCAPE;
               default:     status_in = ST_EOS_SCAN;
            endcase
         end else if (mode_ff == MODE_SCAN) begin
            priority if (depth_ff == '0 && req_in_char == separator_ff) begin
               status_in = ST_SEP;
            end else if (depth_ff == '0 && req_in_char == terminator_ff) begin
               status_in = ST_TERM;
            end else if (op != CL_NONE && depth_ff == DEPTH_MAX) begin
               status_in = ST_OVERFLOW;
            end else begin
               echo_in = req_in_char;
               priority if (req_in_char == CHAR_DQUOTE || req_in_char == CHAR_SQUOTE) begin
                  quote_in = (req_in_char == CHAR_SQUOTE);
                  mode_in  = MODE_STRING;
               end else if (op != CL_NONE) begin
                  stack_cmd.push = 1'b1;
                  depth_in       = depth_ff + 1'b1;
                  expect_in      = op;
               end else if (depth_ff != '0 && closer_match(expect_ff, req_in_char)) begin
                  stack_cmd.pop = 1'b1;
                  depth_in      = depth_ff - 1'b1;
                  expect_in     = stack_value[0];
               end else begin
                  echo_in = req_in_char;
               end
            end
         end else if (mode_ff == MODE_STRING) begin
            echo_in = req_in_char;
            if (req_in_char == CHAR_BACKSLASH || req_in_char == CHAR_BACKTICK) begin
               mode_in = MODE_ESCAPE;
            end else if (req_in_char == delim) begin
               mode_in  = MODE_SCAN;
               quote_in = 1'b0;
            end
         end else begin
            echo_in = req_in_char;
            mode_in = MODE_STRING;
         end
         // every non-accept status restarts the scanner; stack contents stay
         if (status_in != ST_ACCEPT) begin
            mode_in   = MODE_SCAN;
            quote_in  = 1'b0;
            depth_in  = '0;
            expect_in = CL_NONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         separator_ff  <= SEPARATOR_RESET;
         terminator_ff <= TERMINATOR_RESET;
         mode_ff       <= MODE_SCAN;
         quote_ff      <= 1'b0;
         depth_ff      <= '0;
         expect_ff     <= CL_NONE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index_type'(csr_index))
               CSR_SEPARATOR:  separator_ff  <= csr_wdata;
               CSR_TERMINATOR: terminator_ff <= csr_wdata;
               default:        separator_ff  <= separator_ff;
            endcase
         end
         mode_ff      <= mode_in;
         quote_ff     <= quote_in;
         depth_ff     <= depth_in;
         expect_ff    <= expect_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      echo_ff   <= echo_in;
      status_ff <= status_in;
   end

   // cell 0 sits just under the top closer register
   genvar g;
   generate
      for (g = 0; g < MAX_NEST; g++) begin : g_cell
         closer_type above_w;
         closer_type below_w;
         if (g == 0) begin : g_top
            assign above_w = expect_ff;
         end else begin : g_mid
            assign above_w = stack_value[g-1];
         end
         if (g == MAX_NEST - 1) begin : g_bot
            assign below_w = CL_NONE;
         end else begin : g_inner
            assign below_w = stack_value[g+1];
         end
         bas_stack_cell u_cell (
            .clock (clock),
            .cmd   (stack_cmd),
            .above (above_w),
            .below (below_w),
            .value (stack_value[g])
         );
      end
   endgenerate

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_echo_char = echo_ff;
   assign rsp_status    = status_ff;

   a_depth_range: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DEPTH_MAX)
      else $error("nesting depth beyond limit");

   a_top_at_zero: assert property (@(posedge clock) disable iff (reset)
      (depth_ff == '0) == (expect_ff == CL_NONE))
      else $error("expected closer out of step with depth");

   a_eos_restart: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_at_end |=> mode_ff == MODE_SCAN && depth_ff == '0)
      else $error("scanner not restarted after end of stream");

   a_echo_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff != ST_ACCEPT |-> echo_ff == 8'd0)
      else $error("echo not cleared on completion word");

   a_push_step: assert property (@(posedge clock) disable iff (reset)
      stack_cmd.push |=> depth_ff == $past(depth_ff) + 1'b1 && stack_value[0] == $past(expect_ff))
      else $error("stack push lost the saved closer");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for balanced_argument_splitter
// Drives character words through the valid/stall request channel and checks
// every result word against an in-bench scanner model that tracks mode,
// quote, nesting depth and closer stack. Covers overflow, strings, escapes,
// end of stream, several separator/terminator settings and long random text
// with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_top;
   import bas_pkg::*;

   localparam int NEST_LIMIT  = 16;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct {
      logic [7:0] echo;
      status_type status;
   } scan_word_type;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_char = 8'h00;
   logic       req_at_end  = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall   = 1'b0;
   logic [7:0] rsp_echo_char;
   logic [2:0] rsp_status;
   logic       csr_wr_en   = 1'b0;
   logic [0:0] csr_index   = 1'b0;
   logic [7:0] csr_wdata   = 8'h00;

   // scanner model state
   logic [7:0] sep_char  = SEPARATOR_RESET;
   logic [7:0] term_char = TERMINATOR_RESET;
   mode_type   mode      = MODE_SCAN;
   logic       in_single = 1'b0;
   int         depth     = 0;
   closer_type top_closer = CL_NONE;
   closer_type closer_stack [NEST_LIMIT];

   scan_word_type scan_words_due [$];
   int         mismatches  = 0;
   int         cycle_count = 0;
   int         rsp_hold    = 0;
   bit         req_gaps_on   = 1'b1;
   bit         rsp_stalls_on = 1'b1;

   balanced_argument_splitter #(.MAX_NEST(NEST_LIMIT)) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_in_char   (req_in_char),
      .req_at_end    (req_at_end),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_echo_char (rsp_echo_char),
      .rsp_status    (rsp_status),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic closer_type opener_code(input logic [7:0] ch);
      case (ch)
         CHAR_LPAREN:   return CL_PAREN;
         CHAR_LBRACE:   return CL_BRACE;
         CHAR_LBRACKET: return CL_BRACKET;
         default:       return CL_NONE;
      endcase
   endfunction

   function automatic logic [7:0] closer_byte(input closer_type k);
      case (k)
         CL_PAREN:   return CHAR_RPAREN;
         CL_BRACE:   return CHAR_RBRACE;
         CL_BRACKET: return CHAR_RBRACKET;
         default:    return 8'h00;
      endcase
   endfunction

   function automatic void restart_scan();
      mode       = MODE_SCAN;
      in_single  = 1'b0;
      depth      = 0;
      top_closer = CL_NONE;
   endfunction

   // queues a predicted word at the tail
   function automatic void add_due_word(input scan_word_type w);
      scan_words_due.insert(scan_words_due.size(), w);
   endfunction

   // advances the scanner model by one word and returns the result it gives
   function automatic scan_word_type scan_step(input logic [7:0] ch, input logic eos);
      scan_word_type w;
      closer_type op;
      logic [7:0] delim;
      w.echo   = 8'h00;
      w.status = ST_ACCEPT;
      op = opener_code(ch);
      if (eos) begin
         case (mode)
            MODE_STRING: w.status = ST_EOS_STRING;
            MODE_ESCAPE: w.status = ST_EOS_ESCAPE;
            default:     w.status = ST_EOS_SCAN;
         endcase
         restart_scan();
      end else if (mode == MODE_SCAN) begin
         if (depth == 0 && ch == sep_char) begin
            w.status = ST_SEP;
            restart_scan();
         end else if (depth == 0 && ch == term_char) begin
            w.status = ST_TERM;
            restart_scan();
         end else if (op != CL_NONE && depth >= NEST_LIMIT) begin
            w.status = ST_OVERFLOW;
            restart_scan();
         end else begin
            w.echo = ch;
            if (ch == CHAR_DQUOTE || ch == CHAR_SQUOTE) begin
               in_single = (ch == CHAR_SQUOTE);
               mode = MODE_STRING;
            end else if (op != CL_NONE) begin
               closer_stack[depth] = top_closer;
               depth++;
               top_closer = op;
            end else if (top_closer != CL_NONE && depth > 0 &&
                         ch == closer_byte(top_closer)) begin
               depth--;
               top_closer = closer_stack[depth];
            end
         end
      end else if (mode == MODE_STRING) begin
         delim = in_single ? CHAR_SQUOTE : CHAR_DQUOTE;
         w.echo = ch;
         if (ch == CHAR_BACKSLASH || ch == CHAR_BACKTICK) begin
            mode = MODE_ESCAPE;
         end else if (ch == delim) begin
            mode = MODE_SCAN;
            in_single = 1'b0;
         end
      end else begin
         w.echo = ch;
         mode = MODE_STRING;
      end
      return w;
   endfunction

   task automatic flag_mismatch(input string what, input int want, input int got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch on %s: expected %0d, got %0d", what, want, got);
   endtask

   // result side: check each accepted word, then draw the stall before the next
   always @(posedge clock) begin
      scan_word_type due;
      int hold_next;
      if (reset) begin
         rsp_hold = 0;
         rsp_stall <= 1'b0;
      end else begin
         hold_next = (rsp_hold > 0) ? rsp_hold - 1 : 0;
         if (rsp_valid && !rsp_stall) begin
            if (scan_words_due.size() == 0) begin
               flag_mismatch("unexpected word, status", -1, int'(rsp_status));
            end else begin
               due = scan_words_due.pop_front();
               if (rsp_echo_char !== due.echo)
                  flag_mismatch("echo_char", int'(due.echo), int'(rsp_echo_char));
               if (rsp_status !== due.status)
                  flag_mismatch("status", int'(due.status), int'(rsp_status));
            end
            hold_next = rsp_stalls_on ? $urandom_range(0, 6) : 0;
         end
         rsp_hold = hold_next;
         rsp_stall <= (hold_next != 0);
      end
   end

   task automatic send_word(input logic [7:0] ch, input logic eos);
      int gap;
      gap = req_gaps_on ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_char <= ch;
      req_at_end  <= eos;
      do @(posedge clock); while (req_stall);
      add_due_word(scan_step(ch, eos));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (scan_words_due.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [7:0] val);
      drain_results();
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_SEPARATOR) sep_char = val;
      else term_char = val;
   endtask

   // picks a character that is likely to mean something in the current mode
   function automatic logic [7:0] pick_char(input int open_pct);
      int r;
      r = $urandom_range(0, 99);
      if (mode == MODE_SCAN) begin
         if (r < open_pct) begin
            case ($urandom_range(0, 2))
               0:       return CHAR_LPAREN;
               1:       return CHAR_LBRACE;
               default: return CHAR_LBRACKET;
            endcase
         end
         r = r - open_pct;
         if (r < 18 && top_closer != CL_NONE) return closer_byte(top_closer);
         if (r < 24) begin
            case ($urandom_range(0, 2))
               0:       return CHAR_RPAREN;
               1:       return CHAR_RBRACE;
               default: return CHAR_RBRACKET;
            endcase
         end
         if (r < 30) return $urandom_range(0, 1) ? CHAR_SQUOTE : CHAR_DQUOTE;
         if (r < 37) return $urandom_range(0, 1) ? sep_char : term_char;
         return 8'($urandom_range(0, 255));
      end else if (mode == MODE_STRING) begin
         if (r < 15) return in_single ? CHAR_SQUOTE : CHAR_DQUOTE;
         if (r < 25) return $urandom_range(0, 1) ? CHAR_BACKSLASH : CHAR_BACKTICK;
         if (r < 32) return in_single ? CHAR_DQUOTE : CHAR_SQUOTE;
         return 8'($urandom_range(0, 255));
      end
      if (r < 30) return in_single ? CHAR_SQUOTE : CHAR_DQUOTE;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic send_random(input int count, input int open_pct);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < 2) send_word(8'($urandom_range(0, 255)), 1'b1);
         else send_word(pick_char(open_pct), 1'b0);
      end
   endtask

   // fill the closer stack with all kinds, then one opener too many
   task automatic test_overflow();
      for (int i = 0; i < NEST_LIMIT; i++) begin
         case (i % 3)
            0:       send_word(CHAR_LPAREN, 1'b0);
            1:       send_word(CHAR_LBRACKET, 1'b0);
            default: send_word(CHAR_LBRACE, 1'b0);
         endcase
      end
      send_word(CHAR_LBRACKET, 1'b0);
   endtask

   task automatic test_directed_text();
      send_word(CHAR_RBRACKET, 1'b0);   // closer at depth zero is text
      send_word(8'h01, 1'b0);
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b0);
      send_word(SEPARATOR_RESET, 1'b0);
      send_word(TERMINATOR_RESET, 1'b0);
      send_word(CHAR_LPAREN, 1'b0);
      send_word(SEPARATOR_RESET, 1'b0); // separator inside nesting is text
      send_word(CHAR_RBRACKET, 1'b0);   // wrong closer
      send_word(8'h01, 1'b0);           // sentinel never closes
      send_word(CHAR_RPAREN, 1'b0);
      send_word(CHAR_DQUOTE, 1'b0);
      send_word(SEPARATOR_RESET, 1'b0);
      send_word(CHAR_BACKSLASH, 1'b0);
      send_word(CHAR_DQUOTE, 1'b0);     // escaped delimiter
      send_word(CHAR_SQUOTE, 1'b0);     // other quote is plain in string
      send_word(CHAR_DQUOTE, 1'b0);
      send_word(CHAR_SQUOTE, 1'b0);
      send_word(CHAR_BACKTICK, 1'b0);
      send_word(8'hA5, 1'b1);           // end of stream in escape
      send_word(CHAR_SQUOTE, 1'b0);
      send_word(8'h5A, 1'b1);           // end of stream in string
      send_word(CHAR_LBRACE, 1'b0);
      send_word(8'hFF, 1'b1);           // end of stream in scan
   endtask

   task automatic test_config_settings();
      logic [7:0] seps  [5] = '{8'h00, 8'hFF, CHAR_LPAREN, CHAR_RBRACKET, SEPARATOR_RESET};
      logic [7:0] terms [5] = '{8'hFF, 8'h00, CHAR_LPAREN, CHAR_RBRACE, TERMINATOR_RESET};
      for (int s = 0; s < 5; s++) begin
         write_csr(CSR_SEPARATOR, seps[s]);
         write_csr(CSR_TERMINATOR, terms[s]);
         send_word(8'h00, 1'b1);        // back to depth zero
         send_word(seps[s], 1'b0);
         send_word(terms[s], 1'b0);
         send_word(CHAR_LBRACKET, 1'b0);
         send_word(terms[s], 1'b0);
         send_random(40, 20);
      end
   endtask

   task automatic test_random_text();
      int idle_mode;
      for (int seg = 0; seg < 13; seg++) begin
         idle_mode = $urandom_range(0, 3);
         req_gaps_on   = idle_mode[0];
         rsp_stalls_on = idle_mode[1];
         if (seg == 6) drain_results();  // let the result side catch up fully
         send_random(100, ($urandom_range(0, 3) == 0) ? 50 : 18);
      end
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_overflow();
      test_directed_text();
      test_config_settings();
      test_random_text();
      drain_results();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && scan_words_due.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== balanced_argument_splitter.f =====
design/bas_pkg.sv
design/bas_stack_cell.sv
design/balanced_argument_splitter.sv
sim/tb_top.sv
